[sv/iwc_pkg.sv]
// Shared types and constants for the Ising Wolff cluster engine.
// Item structs, command codes, register map and neighbour offsets.
// No dependencies.
package iwc_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_FLIP    = 2'd2,
    CMD_MEASURE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] row;
    logic [6:0] col;
    logic       spin_value;
  } in_item_t;

  typedef struct packed {
    logic               spin_out;
    logic        [14:0] cluster_size;
    logic signed [19:0] energy;
    logic signed [15:0] magnet_sum;
  } out_item_t;

  // Register map, indexed by paddr[3:2]
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_COUPLING  = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_RNG_SEED  = 2'd2;

  localparam logic signed [3:0] COUPLING_RST  = 4'sd1;
  localparam logic [15:0]       THRESHOLD_RST = 16'd20589;
  localparam logic [31:0]       RNG_SEED_RST  = 32'd1;

  // Generator control between top level and the xorshift unit
  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] seed;
  } rng_ctl_t;

  // Neighbour order: (+1,+1) (+1,0) (+1,-1) (0,+1) (0,-1) (-1,+1) (-1,0) (-1,-1)
  localparam logic signed [1:0] NB_DR [8] = '{2'sd1, 2'sd1, 2'sd1, 2'sd0,
                                              2'sd0, -2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] NB_DC [8] = '{2'sd1, 2'sd0, -2'sd1, 2'sd1,
                                              -2'sd1, 2'sd1, 2'sd0, -2'sd1};

endpackage

[sv/iwc_rng.sv]
// xorshift32 generator for the cluster bond draws.
// Depends on iwc_pkg (rng_ctl_t).
module iwc_rng import iwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rng_ctl_t    ctl,
  output logic [31:0] rng_next
);

  logic [31:0] rng_r;
  logic [31:0] x1;
  logic [31:0] x2;

  always_comb begin
    x1       = rng_r ^ (rng_r << 13);
    x2       = x1 ^ (x1 >> 17);
    rng_next = x2 ^ (x2 << 5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= 32'd1;
    end else if (ctl.load) begin
      // zero seed would lock the generator
      rng_r <= (ctl.seed == 32'd0) ? 32'd1 : ctl.seed;
    end else if (ctl.step) begin
      rng_r <= rng_next;
    end
  end

endmodule

[sv/ising_wolff_cluster_engine.sv]
// Ising Wolff cluster engine: SIDE x SIDE toroidal lattice, eight neighbours per site.
// Depends on iwc_pkg and iwc_rng.
//
// One command in, one result out. A cluster flip tests each neighbour of every
// cluster site (8 per site) in S_GROW then S_CHECK, pops the stack in S_GROW then
// S_POP, then sweeps the lattice to flip and unmark the cluster; measure makes
// one lattice read per cycle, for the site and each of its four forward neighbours.
// The pacing of both is set by the single read port of the lattice memory.
// After reset a clearing pass loads every spin to +1 before the first command is
// taken; configuration writes are taken during it. The result register lets a new
// command start while the previous result still waits on out_ready.
module ising_wolff_cluster_engine import iwc_pkg::*; #(
  parameter int SIDE = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SITES = SIDE * SIDE;
  localparam int CW    = $clog2(SIDE);
  localparam int AW    = $clog2(SITES);
  localparam int SPW   = AW + 1;          // stack pointer, counts to SITES
  localparam int SKW   = 2 * CW + 4;      // stack entry: row, col, next neighbour
  localparam int PW    = AW + 4;          // half pair sum, signed
  localparam int MW    = AW + 2;          // magnetization, signed

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_READ_WAIT, S_SEED, S_GROW, S_CHECK,
    S_POP, S_SWEEP, S_MEAS, S_MEAS_END, S_MEAS_FIN, S_RESP
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [3:0] coupling_r;
  logic [15:0]       thresh_r;
  logic [31:0]       seed_r;
  logic              cfg_wr;
  rng_ctl_t          rng_ctl;
  logic [31:0]       rng_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r <= COUPLING_RST;
      thresh_r   <= THRESHOLD_RST;
      seed_r     <= RNG_SEED_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_COUPLING:  coupling_r <= pwdata[3:0];
        REG_THRESHOLD: thresh_r   <= pwdata[15:0];
        REG_RNG_SEED:  seed_r     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COUPLING:  prdata = {28'd0, coupling_r};
      REG_THRESHOLD: prdata = {16'd0, thresh_r};
      REG_RNG_SEED:  prdata = seed_r;
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Row/column reduction modulo SIDE: constant table over the 7-bit inputs
  // ---------------------------------------------------------------------
  logic [CW-1:0] mod_tab [128];
  for (genvar g = 0; g < 128; g++) begin : g_mod
    assign mod_tab[g] = CW'(g % SIDE);
  end

  function automatic logic [AW-1:0] site_addr(logic [CW-1:0] r, logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(SIDE)) + AW'(c);
  endfunction

  // toroidal step of one coordinate by -1, 0 or +1
  function automatic logic [CW-1:0] wrap_step(logic [CW-1:0] v, logic signed [1:0] d);
    logic [CW-1:0] res;
    res = v;
    if (d == 2'sd1) begin
      res = (v == CW'(SIDE - 1)) ? '0 : v + 1'b1;
    end else if (d == -2'sd1) begin
      res = (v == '0) ? CW'(SIDE - 1) : v - 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Memories: lattice {mark, spin} and the walk stack
  // ---------------------------------------------------------------------
  logic [1:0]     lat_mem [SITES];
  logic [1:0]     lat_rdata_r;
  logic [AW-1:0]  lat_ra;
  logic           lat_we;
  logic [AW-1:0]  lat_wa;
  logic [1:0]     lat_wd;

  logic [SKW-1:0] stk_mem [SITES];
  logic [SKW-1:0] stk_rdata_r;
  logic [AW-1:0]  stk_ra;
  logic           stk_we;
  logic [AW-1:0]  stk_wa;
  logic [SKW-1:0] stk_wd;

  always_ff @(posedge clk) begin
    if (lat_we) begin
      lat_mem[lat_wa] <= lat_wd;
    end
    lat_rdata_r <= lat_mem[lat_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rdata_r <= stk_mem[stk_ra];
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]      row_r, row_nxt;        // command site, or measure scan site
  logic [CW-1:0]      col_r, col_nxt;
  logic               spin_r, spin_nxt;      // spin to write, or cluster spin
  logic [CW-1:0]      top_row_r, top_row_nxt;
  logic [CW-1:0]      top_col_r, top_col_nxt;
  logic [3:0]         top_k_r, top_k_nxt;    // next neighbour of stack top
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [SPW-1:0]     count_r, count_nxt;
  logic [CW-1:0]      nb_row_r, nb_row_nxt;
  logic [CW-1:0]      nb_col_r, nb_col_nxt;
  logic [SPW-1:0]     sweep_addr_r, sweep_addr_nxt;
  logic               sweep_vld_r, sweep_vld_nxt;
  logic [AW-1:0]      sweep_wa_r, sweep_wa_nxt;
  logic [2:0]         meas_ph_r, meas_ph_nxt;
  logic               meas_vld_r, meas_vld_nxt;
  logic [2:0]         meas_ph_d_r, meas_ph_d_nxt;
  logic               self_r, self_nxt;
  logic signed [PW-1:0] pair_r, pair_nxt;
  logic signed [MW-1:0] mag_r, mag_nxt;
  out_item_t          res_r, res_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // scratch for the combinational next-state logic
  logic [CW-1:0]      in_row;
  logic [CW-1:0]      in_col;
  logic [2:0]         k;
  logic [1:0]         mk;
  logic [CW-1:0]      nb_r;
  logic [CW-1:0]      nb_c;
  logic signed [4:0]  neg_j;
  logic signed [PW+4:0] prod;
  logic signed [31:0] e_w;
  logic signed [31:0] m_w;
  logic [31:0]        c_w;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_row = mod_tab[in_data.row];
  assign in_col = mod_tab[in_data.col];
  assign k      = top_k_r[2:0];
  assign mk     = 2'(meas_ph_r - 3'd1);
  assign neg_j  = -(5'(coupling_r));
  assign prod   = neg_j * pair_r;
  assign e_w    = 32'(prod);
  assign m_w    = 32'(mag_r);
  assign c_w    = 32'(count_r);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    spin_nxt       = spin_r;
    top_row_nxt    = top_row_r;
    top_col_nxt    = top_col_r;
    top_k_nxt      = top_k_r;
    sp_nxt         = sp_r;
    count_nxt      = count_r;
    nb_row_nxt     = nb_row_r;
    nb_col_nxt     = nb_col_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_vld_nxt  = 1'b0;
    sweep_wa_nxt   = sweep_wa_r;
    meas_ph_nxt    = meas_ph_r;
    meas_vld_nxt   = 1'b0;
    meas_ph_d_nxt  = meas_ph_r;
    self_nxt       = self_r;
    pair_nxt       = pair_r;
    mag_nxt        = mag_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    nb_r           = '0;
    nb_c           = '0;

    lat_ra = '0;
    lat_we = 1'b0;
    lat_wa = '0;
    lat_wd = '0;
    stk_ra = '0;
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = '0;

    rng_ctl.load = cfg_wr && (paddr[3:2] == REG_RNG_SEED);
    rng_ctl.seed = pwdata;
    rng_ctl.step = 1'b0;

    // measure accumulation works on the registered read data, in the cycle after each read
    if (meas_vld_r) begin
      if (meas_ph_d_r == 3'd0) begin
        self_nxt = lat_rdata_r[0];
        mag_nxt  = lat_rdata_r[0] ? mag_r + MW'(1) : mag_r - MW'(1);
      end else begin
        pair_nxt = (lat_rdata_r[0] == self_r) ? pair_r + PW'(1) : pair_r - PW'(1);
      end
    end

    // sweep write-back: flip and unmark what the cluster marked
    if (sweep_vld_r && lat_rdata_r[1]) begin
      lat_we = 1'b1;
      lat_wa = sweep_wa_r;
      lat_wd = {1'b0, ~lat_rdata_r[0]};
    end

    unique case (state_r)
      S_CLEAR: begin
        lat_we       = 1'b1;
        lat_wa       = clr_addr_r;
        lat_wd       = 2'b01;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(SITES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        lat_ra = site_addr(in_row, in_col);
        if (in_valid) begin
          row_nxt  = in_row;
          col_nxt  = in_col;
          spin_nxt = in_data.spin_value;
          res_nxt  = '0;
          unique case (in_data.cmd)
            CMD_WRITE: state_nxt = S_WRITE;
            CMD_READ:  state_nxt = S_READ_WAIT;
            CMD_FLIP:  state_nxt = S_SEED;
            CMD_MEASURE: begin
              row_nxt     = '0;
              col_nxt     = '0;
              meas_ph_nxt = '0;
              pair_nxt    = '0;
              mag_nxt     = '0;
              state_nxt   = S_MEAS;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_WRITE: begin
        lat_we    = 1'b1;
        lat_wa    = site_addr(row_r, col_r);
        lat_wd    = {1'b0, spin_r};
        state_nxt = S_RESP;
      end

      S_READ_WAIT: begin
        res_nxt.spin_out = lat_rdata_r[0];
        state_nxt        = S_RESP;
      end

      S_SEED: begin
        // seed is marked and counted before the walk
        spin_nxt    = lat_rdata_r[0];
        lat_we      = 1'b1;
        lat_wa      = site_addr(row_r, col_r);
        lat_wd      = {1'b1, lat_rdata_r[0]};
        top_row_nxt = row_r;
        top_col_nxt = col_r;
        top_k_nxt   = '0;
        sp_nxt      = SPW'(1);
        count_nxt   = SPW'(1);
        state_nxt   = S_GROW;
      end

      S_GROW: begin
        if (sp_r == '0) begin
          sweep_addr_nxt = '0;
          state_nxt      = S_SWEEP;
        end else if (top_k_r[3]) begin
          // all eight neighbours tried: pop
          sp_nxt = sp_r - 1'b1;
          if (sp_r != SPW'(1)) begin
            stk_ra    = AW'(sp_r - SPW'(2));
            state_nxt = S_POP;
          end
        end else begin
          nb_r        = wrap_step(top_row_r, NB_DR[k]);
          nb_c        = wrap_step(top_col_r, NB_DC[k]);
          lat_ra      = site_addr(nb_r, nb_c);
          nb_row_nxt  = nb_r;
          nb_col_nxt  = nb_c;
          top_k_nxt   = top_k_r + 1'b1;
          state_nxt   = S_CHECK;
        end
      end

      S_CHECK: begin
        state_nxt = S_GROW;
        if (!lat_rdata_r[1] && (lat_rdata_r[0] == spin_r)) begin
          rng_ctl.step = 1'b1;
          if ((rng_next[31:16] < thresh_r) && (sp_r < SPW'(SITES))) begin
            lat_we      = 1'b1;
            lat_wa      = site_addr(nb_row_r, nb_col_r);
            lat_wd      = {1'b1, spin_r};
            stk_we      = 1'b1;
            stk_wa      = AW'(sp_r - 1'b1);
            stk_wd      = {top_row_r, top_col_r, top_k_r};
            top_row_nxt = nb_row_r;
            top_col_nxt = nb_col_r;
            top_k_nxt   = '0;
            sp_nxt      = sp_r + 1'b1;
            count_nxt   = count_r + 1'b1;
          end
        end
      end

      S_POP: begin
        {top_row_nxt, top_col_nxt, top_k_nxt} = stk_rdata_r;
        state_nxt = S_GROW;
      end

      S_SWEEP: begin
        if (sweep_addr_r != SPW'(SITES)) begin
          lat_ra         = sweep_addr_r[AW-1:0];
          sweep_wa_nxt   = sweep_addr_r[AW-1:0];
          sweep_vld_nxt  = 1'b1;
          sweep_addr_nxt = sweep_addr_r + 1'b1;
        end else if (!sweep_vld_r) begin
          res_nxt.cluster_size = (c_w > 32'd32767) ? 15'h7fff : c_w[14:0];
          state_nxt            = S_RESP;
        end
      end

      S_MEAS: begin
        // phase 0 reads the site, phases 1..4 its forward neighbours
        if (meas_ph_r == 3'd0) begin
          lat_ra = site_addr(row_r, col_r);
        end else begin
          lat_ra = site_addr(wrap_step(row_r, NB_DR[mk]), wrap_step(col_r, NB_DC[mk]));
        end
        meas_vld_nxt = 1'b1;
        if (meas_ph_r == 3'd4) begin
          meas_ph_nxt = '0;
          if (col_r == CW'(SIDE - 1)) begin
            col_nxt = '0;
            if (row_r == CW'(SIDE - 1)) begin
              state_nxt = S_MEAS_END;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end else begin
          meas_ph_nxt = meas_ph_r + 1'b1;
        end
      end

      S_MEAS_END: begin
        state_nxt = S_MEAS_FIN;
      end

      S_MEAS_FIN: begin
        if (e_w > 32'sd524287) begin
          res_nxt.energy = 20'sd524287;
        end else if (e_w < -32'sd524288) begin
          res_nxt.energy = -20'sd524288;
        end else begin
          res_nxt.energy = e_w[19:0];
        end
        if (m_w > 32'sd32767) begin
          res_nxt.magnet_sum = 16'sd32767;
        end else if (m_w < -32'sd32768) begin
          res_nxt.magnet_sum = -16'sd32768;
        end else begin
          res_nxt.magnet_sum = m_w[15:0];
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      sp_r        <= '0;
      sweep_vld_r <= 1'b0;
      meas_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      sp_r        <= sp_nxt;
      sweep_vld_r <= sweep_vld_nxt;
      meas_vld_r  <= meas_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    spin_r       <= spin_nxt;
    top_row_r    <= top_row_nxt;
    top_col_r    <= top_col_nxt;
    top_k_r      <= top_k_nxt;
    count_r      <= count_nxt;
    nb_row_r     <= nb_row_nxt;
    nb_col_r     <= nb_col_nxt;
    sweep_addr_r <= sweep_addr_nxt;
    sweep_wa_r   <= sweep_wa_nxt;
    meas_ph_r    <= meas_ph_nxt;
    meas_ph_d_r  <= meas_ph_d_nxt;
    self_r       <= self_nxt;
    pair_r       <= pair_nxt;
    mag_r        <= mag_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  iwc_rng u_rng (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rng_ctl),
    .rng_next (rng_next)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(SITES))
    else $error("walk stack pointer beyond lattice size");

  a_count_ge_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW || state_r == S_CHECK || state_r == S_POP) |-> count_r >= sp_r)
    else $error("cluster count below stack depth");

  a_empty_to_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW && sp_r == '0) |=> state_r == S_SWEEP)
    else $error("empty walk did not start the sweep");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !lat_we && !stk_we)
    else $error("memory write while no command is active");

  a_push_on_draw: assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> rng_ctl.step)
    else $error("stack push without a bond draw");

endmodule
